// ----- hw/rtl/sfss_pkg.sv -----
// sfss_pkg: constants, stage payload types and the glyph table for the
// signed fixed-point to seven-segment core. No dependencies.
`default_nettype none

package sfss_pkg;

   localparam int VALUE_WIDTH = 18;
   localparam int DEC_WIDTH   = 2;
   localparam int SEG_WIDTH   = 8;
   localparam int MAG_WIDTH   = 17;   // saturated magnitude, up to 99999
   localparam int RED_WIDTH   = 14;   // magnitude after reduction, up to 9999
   localparam int Q10_WIDTH   = 10;   // up to 999
   localparam int Q100_WIDTH  = 7;    // up to 99
   localparam int DIGIT_WIDTH = 4;

   localparam logic [MAG_WIDTH-1:0] VALUE_LIMIT = 17'd99999;
   localparam logic [MAG_WIDTH-1:0] TENS_LIMIT  = 17'd10000;
   localparam logic [MAG_WIDTH-1:0] NEG_LIMIT   = 17'd1000;

   // reciprocals of ten, each exact over the range it is used on
   localparam logic [19:0] RECIP_TEN_23 = 20'd838861;   // x < 2^17, shift 23
   localparam logic [12:0] RECIP_TEN_16 = 13'd6554;     // x < 2^14, shift 16
   localparam logic [7:0]  RECIP_TEN_11 = 8'd205;       // x < 1020, shift 11

   localparam logic [SEG_WIDTH-1:0] MINUS_GLYPH = 8'h02;
   localparam logic [SEG_WIDTH-1:0] BLANK_GLYPH = 8'h00;
   localparam logic [SEG_WIDTH-1:0] ZERO_GLYPH  = 8'hfc;
   localparam logic [DEC_WIDTH-1:0] ONE_DECIMAL = 2'd1;

   // magnitude stage
   typedef struct packed {
      logic                 neg;
      logic [DEC_WIDTH-1:0] dec;
      logic [MAG_WIDTH-1:0] mag;
   } mag_type;

   // after the optional division by ten
   typedef struct packed {
      logic                 neg;
      logic [DEC_WIDTH-1:0] dec;
      logic [RED_WIDTH-1:0] mag;
   } reduced_type;

   // ones digit split off
   typedef struct packed {
      logic                   neg;
      logic [DEC_WIDTH-1:0]   dec;
      logic [Q10_WIDTH-1:0]   q10;
      logic [DIGIT_WIDTH-1:0] ones;
   } ones_type;

   // tens digit split off
   typedef struct packed {
      logic                   neg;
      logic [DEC_WIDTH-1:0]   dec;
      logic                   tens_shown;
      logic [Q100_WIDTH-1:0]  q100;
      logic [DIGIT_WIDTH-1:0] tens;
      logic [DIGIT_WIDTH-1:0] ones;
   } tens_type;

   typedef struct packed {
      logic [SEG_WIDTH-1:0] seg_digit0;
      logic [SEG_WIDTH-1:0] seg_digit1;
      logic [SEG_WIDTH-1:0] seg_digit2;
      logic [SEG_WIDTH-1:0] seg_digit3;
      logic                 point_on;
   } result_type;

   // segment pattern of one decimal digit, bit7=a .. bit1=g
   function automatic logic [SEG_WIDTH-1:0] digit_glyph(input logic [DIGIT_WIDTH-1:0] d);
      logic [SEG_WIDTH-1:0] g;
      case (d)
         4'd0:    g = 8'hfc;
         4'd1:    g = 8'h60;
         4'd2:    g = 8'hda;
         4'd3:    g = 8'hf2;
         4'd4:    g = 8'h66;
         4'd5:    g = 8'hb6;
         4'd6:    g = 8'hbe;
         4'd7:    g = 8'he0;
         4'd8:    g = 8'hfe;
         4'd9:    g = 8'hf6;
         default: g = BLANK_GLYPH;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sfss_channels_if.sv -----
// sfss_req_if and sfss_rsp_if: valid/ready channels for requests and results.
// Depends on sfss_pkg for the field widths.
`default_nettype none

interface sfss_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [sfss_pkg::VALUE_WIDTH-1:0] value;
   logic        [sfss_pkg::DEC_WIDTH-1:0]   decimals;

   modport source (output valid, output value, output decimals, input ready);
   modport sink   (input valid, input value, input decimals, output ready);
endinterface

interface sfss_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [sfss_pkg::SEG_WIDTH-1:0]    seg_digit0;
   logic [sfss_pkg::SEG_WIDTH-1:0]    seg_digit1;
   logic [sfss_pkg::SEG_WIDTH-1:0]    seg_digit2;
   logic [sfss_pkg::SEG_WIDTH-1:0]    seg_digit3;
   logic                              point_on;

   modport source (output valid, output seg_digit0, output seg_digit1,
                   output seg_digit2, output seg_digit3, output point_on,
                   input ready);
   modport sink   (input valid, input seg_digit0, input seg_digit1,
                   input seg_digit2, input seg_digit3, input point_on,
                   output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sfss_reduce.sv -----
// sfss_reduce: pipeline stages one and two, magnitude with saturation and
// the optional division by ten. Depends on sfss_pkg.
`default_nettype none

module sfss_reduce (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    in_valid,
   output logic                                         in_ready,
   input  wire logic signed [sfss_pkg::VALUE_WIDTH-1:0] in_value,
   input  wire logic        [sfss_pkg::DEC_WIDTH-1:0]   in_decimals,
   output logic                                         out_valid,
   input  wire logic                                    out_ready,
   output sfss_pkg::reduced_type                        out_data
);
   import sfss_pkg::*;

   logic                   s1_valid_ff;
   mag_type                s1_ff, s1_in;
   logic                   s1_ready;
   logic                   s2_valid_ff;
   reduced_type            s2_ff, s2_in;
   logic                   s2_ready;
   logic [VALUE_WIDTH-1:0] abs_value;
   logic                   reduce;
   logic [36:0]            prod;

   // stage ready chain, a stage takes a request when empty or draining
   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // two's complement magnitude, most negative code gives 2^17 unsigned
   always_comb begin
      abs_value = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
      s1_in.neg = in_value[VALUE_WIDTH-1];
      s1_in.dec = in_decimals;
      if (abs_value > VALUE_WIDTH'(VALUE_LIMIT)) begin
         s1_in.mag = VALUE_LIMIT;
      end else begin
         s1_in.mag = abs_value[MAG_WIDTH-1:0];
      end
   end

   // divide by ten when too long for the display, count clamps at zero
   always_comb begin
      reduce    = s1_ff.neg ? (s1_ff.mag >= NEG_LIMIT) : (s1_ff.mag >= TENS_LIMIT);
      prod      = 37'(s1_ff.mag) * 37'(RECIP_TEN_23);
      s2_in.neg = s1_ff.neg;
      s2_in.mag = reduce ? prod[36:23] : s1_ff.mag[RED_WIDTH-1:0];
      if (reduce && (s1_ff.dec != '0)) begin
         s2_in.dec = s1_ff.dec - 1'b1;
      end else begin
         s2_in.dec = s1_ff.dec;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) s1_ff <= s1_in;
      if (s2_ready && s1_valid_ff) s2_ff <= s2_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/sfss_digit_split.sv -----
// sfss_digit_split: pipeline stages three and four, splitting off the ones
// and tens digits by reciprocal multiplication. Depends on sfss_pkg.
`default_nettype none

module sfss_digit_split (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire sfss_pkg::reduced_type in_data,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output sfss_pkg::tens_type         out_data
);
   import sfss_pkg::*;

   logic         s3_valid_ff;
   ones_type     s3_ff, s3_in;
   logic         s3_ready;
   logic         s4_valid_ff;
   tens_type     s4_ff, s4_in;
   logic         s4_ready;
   logic [26:0]  prod10;
   logic [17:0]  prod100;
   logic [RED_WIDTH-1:0] rest3;
   logic [Q10_WIDTH-1:0] rest4;

   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign in_ready = s3_ready;

   // ones digit: mag - 10 * (mag / 10)
   always_comb begin
      prod10     = 27'(in_data.mag) * 27'(RECIP_TEN_16);
      s3_in.neg  = in_data.neg;
      s3_in.dec  = in_data.dec;
      s3_in.q10  = prod10[25:16];
      rest3      = in_data.mag - ((RED_WIDTH'(s3_in.q10) << 3) + (RED_WIDTH'(s3_in.q10) << 1));
      s3_in.ones = rest3[DIGIT_WIDTH-1:0];
   end

   // tens digit from the quotient left by the ones stage
   always_comb begin
      prod100          = 18'(s3_ff.q10) * 18'(RECIP_TEN_11);
      s4_in.neg        = s3_ff.neg;
      s4_in.dec        = s3_ff.dec;
      s4_in.ones       = s3_ff.ones;
      s4_in.tens_shown = (s3_ff.q10 != '0);
      s4_in.q100       = prod100[17:11];
      rest4            = s3_ff.q10 - ((Q10_WIDTH'(s4_in.q100) << 3) + (Q10_WIDTH'(s4_in.q100) << 1));
      s4_in.tens       = rest4[DIGIT_WIDTH-1:0];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s3_ready) s3_valid_ff <= in_valid;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (s3_ready && in_valid) s3_ff <= s3_in;
      if (s4_ready && s3_valid_ff) s4_ff <= s4_in;
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/sfss_encode.sv -----
// sfss_encode: pipeline stage five and output register, hundreds and
// thousands split, blanking, minus glyph and segment encoding. Depends on sfss_pkg.
`default_nettype none

module sfss_encode (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire sfss_pkg::tens_type in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output sfss_pkg::result_type    out_data
);
   import sfss_pkg::*;

   logic                   s5_valid_ff;
   result_type             s5_ff, s5_in;
   logic [14:0]            prod1000;
   logic [DIGIT_WIDTH-1:0] thous;
   logic [Q100_WIDTH-1:0]  rest5;
   logic [DIGIT_WIDTH-1:0] hund;

   assign in_ready = !s5_valid_ff || out_ready;

   // split the last two digits and pick each glyph
   always_comb begin
      prod1000 = 15'(in_data.q100) * 15'(RECIP_TEN_11);
      thous    = prod1000[14:11];
      rest5    = in_data.q100 - ((Q100_WIDTH'(thous) << 3) + (Q100_WIDTH'(thous) << 1));
      hund     = rest5[DIGIT_WIDTH-1:0];

      s5_in.seg_digit3 = digit_glyph(in_data.ones);

      // zero before the point kept with one decimal place and a single digit
      if (in_data.tens_shown) begin
         s5_in.seg_digit2 = digit_glyph(in_data.tens);
      end else if (in_data.dec == ONE_DECIMAL) begin
         s5_in.seg_digit2 = ZERO_GLYPH;
      end else begin
         s5_in.seg_digit2 = BLANK_GLYPH;
      end

      s5_in.seg_digit1 = (in_data.q100 != '0) ? digit_glyph(hund) : BLANK_GLYPH;

      // a negative value always shows the minus in the leftmost place
      if (in_data.neg) begin
         s5_in.seg_digit0 = MINUS_GLYPH;
      end else if (thous != '0) begin
         s5_in.seg_digit0 = digit_glyph(thous);
      end else begin
         s5_in.seg_digit0 = BLANK_GLYPH;
      end

      s5_in.point_on = (in_data.dec != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s5_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) s5_ff <= s5_in;
   end

   assign out_valid = s5_valid_ff;
   assign out_data  = s5_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/signed_fixed_point_to_seven_segment_core.sv -----
// Signed fixed-point to seven-segment core: five-stage pipeline, one request
// per clock unless the result stalls.
//
// Each request carries a signed value and its count of decimal places and
// yields one result of four segment bytes (bit7=a .. bit1=g) and a point flag.
// A request is accepted on any cycle in which req_if.ready is high; with
// rsp_if.ready held high the core sustains one request per clock. The five
// register stages, the first of which captures the request, are magnitude
// and saturation, division by ten, ones split, tens split, then hundreds and
// thousands split with encoding into the output register. Every stage holds
// its own valid bit, so a stalled result leaves the earlier stages free to
// fill. Negative values show a minus in the leftmost digit; too-long values
// drop their last decimal and the point count clamps at zero.
// Depends on sfss_pkg, the channel interfaces and the sfss_ stage modules.
`default_nettype none

module signed_fixed_point_to_seven_segment_core (
   input  wire logic clock,
   input  wire logic reset,
   sfss_req_if.sink  req_if,
   sfss_rsp_if.source rsp_if
);
   import sfss_pkg::*;

   logic        red_valid;
   logic        red_ready;
   reduced_type red_data;
   logic        split_valid;
   logic        split_ready;
   tens_type    split_data;
   result_type  result;

   sfss_reduce u_reduce (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_if.valid),
      .in_ready    (req_if.ready),
      .in_value    (req_if.value),
      .in_decimals (req_if.decimals),
      .out_valid   (red_valid),
      .out_ready   (red_ready),
      .out_data    (red_data)
   );

   sfss_digit_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (red_valid),
      .in_ready  (red_ready),
      .in_data   (red_data),
      .out_valid (split_valid),
      .out_ready (split_ready),
      .out_data  (split_data)
   );

   sfss_encode u_encode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_ready  (split_ready),
      .in_data   (split_data),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (result)
   );

   // result fields onto the channel
   assign rsp_if.seg_digit0 = result.seg_digit0;
   assign rsp_if.seg_digit1 = result.seg_digit1;
   assign rsp_if.seg_digit2 = result.seg_digit2;
   assign rsp_if.seg_digit3 = result.seg_digit3;
   assign rsp_if.point_on   = result.point_on;

endmodule

`default_nettype wire

// ----- hw/rtl/sfss_checker.sv -----
// sfss_checker: port-level assertions on the result channel of the core,
// bound to signed_fixed_point_to_seven_segment_core. Depends on sfss_pkg.
`default_nettype none

module sfss_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [sfss_pkg::SEG_WIDTH-1:0] rsp_seg_digit0,
   input wire logic [sfss_pkg::SEG_WIDTH-1:0] rsp_seg_digit1,
   input wire logic [sfss_pkg::SEG_WIDTH-1:0] rsp_seg_digit2,
   input wire logic [sfss_pkg::SEG_WIDTH-1:0] rsp_seg_digit3,
   input wire logic                           rsp_point_on
);
   import sfss_pkg::*;

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_seg_digit0, rsp_seg_digit1, rsp_seg_digit2,
                  rsp_seg_digit3, rsp_point_on}))
      else $error("stalled result changed");

   // ones digit is never blanked
   a_ones_shown: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_seg_digit3 != BLANK_GLYPH)
      else $error("ones digit blanked");

   // a shown hundreds digit forces a shown tens digit
   a_tens_after_hund: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_seg_digit1 != BLANK_GLYPH |-> rsp_seg_digit2 != BLANK_GLYPH)
      else $error("tens blanked under a shown hundreds digit");

   // a leading zero in the tens place only comes with the point lit
   a_lead_zero_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_seg_digit2 == ZERO_GLYPH && rsp_seg_digit1 == BLANK_GLYPH
         |-> rsp_point_on)
      else $error("leading zero shown without the point");

endmodule

bind signed_fixed_point_to_seven_segment_core sfss_checker u_sfss_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_seg_digit0 (rsp_if.seg_digit0),
   .rsp_seg_digit1 (rsp_if.seg_digit1),
   .rsp_seg_digit2 (rsp_if.seg_digit2),
   .rsp_seg_digit3 (rsp_if.seg_digit3),
   .rsp_point_on   (rsp_if.point_on)
);

`default_nettype wire
